@@ src/bses_pkg.sv @@
// Shared types and constants for the bit stream escape stuffer.
`timescale 1ns / 1ps

package bses_pkg;

  // Default window and pattern length in bits
  localparam int unsigned PatternBitsDef = 8;
  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  // Configuration register width, index width and reset values
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgDataW-1:0] FlagReset = 8'd126;
  localparam logic [CfgDataW-1:0] EscReset = 8'd125;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FLAG = 1'b0,
    REG_ESC  = 1'b1
  } cfg_reg_e;

  // One payload item
  typedef struct packed {
    logic payload_bit;
    logic end_of_payload;
  } in_item_t;

  // One line item
  typedef struct packed {
    logic line_bit;
    logic frame_done;
  } out_item_t;

  // Serializer phases of the back end
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_ESC,
    PH_BODY,
    PH_CLOSE
  } phase_e;

endpackage

@@ src/bses_front.sv @@
// Front end: slides the window over payload items and queues serializer commands.
`timescale 1ns / 1ps

module bses_front #(
  parameter int unsigned PatternBits = bses_pkg::PatternBitsDef,
  parameter int unsigned CntW = $clog2(PatternBits + 1),
  parameter int unsigned CmdW = 3 + CntW + PatternBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bses_pkg::in_item_t     in_item_i,
  input  logic [PatternBits-1:0] flag_i,
  input  logic [PatternBits-1:0] esc_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [CmdW-1:0]        q_cmd_o
);
  import bses_pkg::*;

  typedef struct packed {
    logic                   open_flag;
    logic                   esc;
    logic                   close_flag;
    logic [CntW-1:0]        cnt;
    logic [PatternBits-1:0] word;
  } cmd_t;

  logic [PatternBits-1:0] window_q, window_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic                   open_q, open_d;

  logic                   accept;
  logic [PatternBits-1:0] win_sh;
  logic [CntW-1:0]        fill_new;
  logic                   full_win;
  logic                   match;
  cmd_t                   cmd;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Shift the new bit in; a fresh frame starts from an empty window
  always_comb begin
    if (open_q) begin
      win_sh   = {window_q[PatternBits-2:0], in_item_i.payload_bit};
      fill_new = fill_q + CntW'(1);
    end else begin
      win_sh   = {{(PatternBits-1){1'b0}}, in_item_i.payload_bit};
      fill_new = CntW'(1);
    end
  end

  assign full_win = (fill_new == CntW'(PatternBits));
  assign match    = full_win && ((win_sh == flag_i) || (win_sh == esc_i));

  // Classify the item into a command and the next window state
  always_comb begin
    cmd.open_flag  = !open_q;
    cmd.esc        = match;
    cmd.close_flag = in_item_i.end_of_payload;
    cmd.word       = win_sh;
    window_d       = win_sh;
    fill_d         = fill_new;
    if (match) begin
      cmd.cnt  = CntW'(PatternBits);
      window_d = '0;
      fill_d   = '0;
    end else if (full_win) begin
      cmd.cnt  = in_item_i.end_of_payload ? CntW'(PatternBits) : CntW'(1);
      // A plain shift sends only the oldest bit, placed at bit 0
      if (!in_item_i.end_of_payload) begin
        cmd.word = {{(PatternBits-1){1'b0}}, win_sh[PatternBits-1]};
      end
      window_d = {1'b0, win_sh[PatternBits-2:0]};
      fill_d   = CntW'(PatternBits - 1);
    end else begin
      cmd.cnt  = in_item_i.end_of_payload ? fill_new : '0;
    end
    open_d = 1'b1;
    if (in_item_i.end_of_payload) begin
      window_d = '0;
      fill_d   = '0;
      open_d   = 1'b0;
    end
  end

  // Queue only commands that put bits on the line
  assign q_push_o = accept &&
                    (cmd.open_flag || cmd.esc || cmd.close_flag || (cmd.cnt != '0));
  assign q_cmd_o  = cmd;

  // Advance the window state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      open_q   <= 1'b0;
    end else if (accept) begin
      window_q <= window_d;
      fill_q   <= fill_d;
      open_q   <= open_d;
    end
  end

`ifndef ASSERT_OFF
  // The last payload bit always closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.end_of_payload) |=> !open_q)
    else $error("frame still open after last payload bit");
`endif

endmodule

@@ src/bses_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module bses_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = bses_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  import bses_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);

  logic [Width-1:0]  entry_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;

  assign full_o  = (count_q == CountW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CountW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty command queue");
`endif

endmodule

@@ src/bses_back.sv @@
// Back end: serializes queued commands into line bits through an output register.
`timescale 1ns / 1ps

module bses_back #(
  parameter int unsigned PatternBits = bses_pkg::PatternBitsDef,
  parameter int unsigned CntW = $clog2(PatternBits + 1),
  parameter int unsigned CmdW = 3 + CntW + PatternBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [PatternBits-1:0] flag_i,
  input  logic [PatternBits-1:0] esc_i,
  input  logic                   q_valid_i,
  input  logic [CmdW-1:0]        q_cmd_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bses_pkg::out_item_t    out_item_o
);
  import bses_pkg::*;

  localparam int unsigned IdxW = $clog2(PatternBits);

  typedef struct packed {
    logic                   open_flag;
    logic                   esc;
    logic                   close_flag;
    logic [CntW-1:0]        cnt;
    logic [PatternBits-1:0] word;
  } cmd_t;

  // Phase that follows ph for command c, skipping empty ones
  function automatic phase_e after_phase(phase_e ph, cmd_t c);
    phase_e r;
    r = PH_IDLE;
    unique case (ph)
      PH_OPEN: begin
        if (c.esc) r = PH_ESC;
        else if (c.cnt != '0) r = PH_BODY;
        else if (c.close_flag) r = PH_CLOSE;
      end
      PH_ESC: begin
        if (c.cnt != '0) r = PH_BODY;
        else if (c.close_flag) r = PH_CLOSE;
      end
      PH_BODY: begin
        if (c.close_flag) r = PH_CLOSE;
      end
      default: r = PH_IDLE;
    endcase
    return r;
  endfunction

  // Bit index that a phase starts at
  function automatic logic [IdxW-1:0] start_idx(phase_e ph, cmd_t c);
    logic [CntW-1:0] last_pos;
    last_pos = c.cnt - CntW'(1);
    return (ph == PH_BODY) ? last_pos[IdxW-1:0] : IdxW'(PatternBits - 1);
  endfunction

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  cmd_t            cmd_q, cmd_d;
  cmd_t            q_cmd;
  phase_e          nxt, first;
  logic            load_ok;
  logic            can_emit;
  logic            emit;
  out_item_t       bit_item;
  logic            out_valid_q;
  out_item_t       out_item_q;

  assign q_cmd    = q_cmd_i;
  assign first    = q_cmd.open_flag ? PH_OPEN : after_phase(PH_OPEN, q_cmd);
  assign can_emit = !out_valid_q || !out_stall_i;

  // Next state: step through bits, move to the next phase, load the next command
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    q_pop_o = 1'b0;
    load_ok = 1'b0;
    nxt     = PH_IDLE;
    if (phase_q == PH_IDLE) begin
      load_ok = 1'b1;
    end else if (can_emit) begin
      if (idx_q != '0) begin
        idx_d = idx_q - IdxW'(1);
      end else begin
        nxt = after_phase(phase_q, cmd_q);
        if (nxt != PH_IDLE) begin
          phase_d = nxt;
          idx_d   = start_idx(nxt, cmd_q);
        end else begin
          phase_d = PH_IDLE;
          load_ok = 1'b1;
        end
      end
    end
    if (load_ok && q_valid_i) begin
      q_pop_o = 1'b1;
      cmd_d   = q_cmd;
      phase_d = first;
      idx_d   = start_idx(first, q_cmd);
    end
  end

  // Outputs: select the current line bit
  always_comb begin
    emit = can_emit && (phase_q != PH_IDLE);
    bit_item.frame_done = (phase_q == PH_CLOSE) && (idx_q == '0);
    unique case (phase_q)
      PH_OPEN, PH_CLOSE: bit_item.line_bit = flag_i[idx_q];
      PH_ESC:            bit_item.line_bit = esc_i[idx_q];
      PH_BODY:           bit_item.line_bit = cmd_q.word[idx_q];
      default:           bit_item.line_bit = 1'b0;
    endcase
  end

  // Hold sequencer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (can_emit) begin
        out_valid_q <= emit;
      end
    end
  end

  // Hold command and output payload
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    if (emit) begin
      out_item_q <= bit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // Closing flag ends on its own least significant bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.frame_done) |-> (out_item_q.line_bit == flag_i[0]))
    else $error("frame_done on a bit that is not the flag's last bit");
  // A command is taken only when the sequencer is free or finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> ((phase_q == PH_IDLE) || (can_emit && (idx_q == '0))))
    else $error("command popped while serializer busy");
`endif

endmodule

@@ src/bit_stream_escape_stuffer.sv @@
// Top level of the bit stream escape stuffer: configuration, front, queue and back.
`timescale 1ns / 1ps

// Frames a serial payload with flag delimiters and escape stuffing, one payload bit
// per input item and one line bit per output item. The front end takes a payload bit
// in every cycle while its command queue (QueueDepth entries) has room; the back end
// puts out one line bit per cycle while it holds a command and the output side does
// not stall. Line bits per payload bit set the rate: one for a plain bit, an escaped
// window costs 2*PatternBits bits spread over the PatternBits items that refill it,
// each frame adds 2*PatternBits flag bits. The flag and escape registers reset to
// 126 and 125; the user must write them only while the block is idle (unenforced).
module bit_stream_escape_stuffer #(
  parameter int unsigned PatternBits = bses_pkg::PatternBitsDef,
  parameter int unsigned QueueDepth = bses_pkg::QueueDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bses_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bses_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [bses_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bses_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bses_pkg::*;

  localparam int unsigned CntW = $clog2(PatternBits + 1);
  localparam int unsigned CmdW = 3 + CntW + PatternBits;

  logic [CfgDataW-1:0]             flag_q, esc_q;
  logic [PatternBits+CfgDataW-1:0] flag_wide, esc_wide;
  logic [PatternBits-1:0]          flag_p, esc_p;
  logic                            q_full, q_push, q_valid, q_pop;
  logic [CmdW-1:0]                 q_wr_cmd, q_rd_cmd;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= FlagReset;
      esc_q  <= EscReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FLAG: flag_q <= cfg_data_i;
        REG_ESC:  esc_q  <= cfg_data_i;
      endcase
    end
  end

  // Use the low PatternBits bits; bits beyond the register read as zero
  assign flag_wide = {{PatternBits{1'b0}}, flag_q};
  assign esc_wide  = {{PatternBits{1'b0}}, esc_q};
  assign flag_p    = flag_wide[PatternBits-1:0];
  assign esc_p     = esc_wide[PatternBits-1:0];

  bses_front #(
    .PatternBits(PatternBits),
    .CntW       (CntW),
    .CmdW       (CmdW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .flag_i    (flag_p),
    .esc_i     (esc_p),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_wr_cmd)
  );

  bses_fifo #(
    .Width(CmdW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wr_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rd_cmd)
  );

  bses_back #(
    .PatternBits(PatternBits),
    .CntW       (CntW),
    .CmdW       (CmdW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flag_i     (flag_p),
    .esc_i      (esc_p),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_rd_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
